// ===== design/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the tuple state table
// Table geometry, request and state codes, and the result record passed
// from the lookup sequencer to the output register.
// ----------------------------------------------------------------------------
package tst_pkg;

    // Table geometry
    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int ENT_W    = KEY_BITS + 2;

    // Request codes
    localparam logic [2:0] REQ_GET     = 3'd0;
    localparam logic [2:0] REQ_EXISTS  = 3'd1;
    localparam logic [2:0] REQ_INS_ANY = 3'd2;
    localparam logic [2:0] REQ_INS_ABS = 3'd3;
    localparam logic [2:0] REQ_DEMOTE  = 3'd4;
    localparam logic [2:0] REQ_DROP    = 3'd5;

    // Tuple state codes
    localparam logic [1:0] ST_ABSENT  = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [1:0] found_state;
        logic       key_found;
        logic       changed;
        logic       newly_added;
        logic       table_full;
    } tst_result_t;

endpackage

// ===== design/tst_ram.sv =====
// ----------------------------------------------------------------------------
// tst_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl: lookup sequencer of the tuple state table
// Scans the filled entries one per cycle through a single key comparator,
// then applies the state transition with at most one RAM write.
// ----------------------------------------------------------------------------
module tst_ctrl
    import tst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          req_type,
    input  logic [63:0]         key,
    output logic                res_valid,
    input  logic                res_ready,
    output tst_result_t         res,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [ENT_W-1:0]    rd_data,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [ENT_W-1:0]    wr_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CMP    = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [2:0]          req_reg, req_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic                hit_reg, hit_next;
    logic [1:0]          fstate_reg, fstate_next;
    tst_result_t         res_reg, res_next;

    logic                key_match;
    logic                last_entry;
    logic                is_full;
    logic [1:0]          new_state;

    // Shared key comparator and scan bounds
    assign key_match  = (rd_data[KEY_BITS-1:0] == key_reg);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign is_full    = (used_reg == CNT_W'(ENTRIES));

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    // Read address: first entry on accept, next entry while comparing
    assign rd_en   = (state_reg == S_IDLE) || (state_reg == S_CMP);
    assign rd_addr = (state_reg == S_CMP) ? idx_reg + IDX_W'(1) : '0;

    assign wr_data = {new_state, key_reg};

    // Sequencer and transition logic
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        used_next   = used_reg;
        hit_next    = hit_reg;
        fstate_next = fstate_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_reg;
        new_state   = ST_PRESENT;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req_type;
                    key_next    = key[KEY_BITS-1:0];
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    fstate_next = ST_ABSENT;
                    state_next  = (used_reg == '0) ? S_DECIDE : S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_match)
                begin
                    hit_next    = 1'b1;
                    slot_next   = idx_reg;
                    fstate_next = rd_data[ENT_W-1:KEY_BITS];
                    state_next  = S_DECIDE;
                end
                else if (last_entry)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                res_next.found_state = fstate_reg;
                res_next.key_found   = hit_reg;
                res_next.changed     = 1'b0;
                res_next.newly_added = 1'b0;
                res_next.table_full  = 1'b0;
                case (req_reg)
                    REQ_INS_ANY, REQ_INS_ABS:
                    begin
                        new_state = ST_PRESENT;
                        if (hit_reg)
                        begin
                            if ((fstate_reg == ST_ABSENT) ||
                                ((req_reg == REQ_INS_ANY) && (fstate_reg == ST_UNKNOWN)))
                            begin
                                wr_en            = 1'b1;
                                res_next.changed = 1'b1;
                            end
                        end
                        else if (!is_full)
                        begin
                            wr_en                = 1'b1;
                            wr_addr              = used_reg[IDX_W-1:0];
                            used_next            = used_reg + CNT_W'(1);
                            res_next.changed     = 1'b1;
                            res_next.newly_added = 1'b1;
                        end
                        else
                        begin
                            res_next.table_full = 1'b1;
                        end
                    end
                    REQ_DEMOTE:
                    begin
                        new_state = ST_UNKNOWN;
                        if (hit_reg && (fstate_reg == ST_PRESENT))
                        begin
                            wr_en            = 1'b1;
                            res_next.changed = 1'b1;
                        end
                    end
                    REQ_DROP:
                    begin
                        new_state = ST_ABSENT;
                        if (hit_reg && (fstate_reg == ST_UNKNOWN))
                        begin
                            wr_en            = 1'b1;
                            res_next.changed = 1'b1;
                        end
                    end
                    default:
                    begin
                        // get, exists and unused codes only report
                    end
                endcase
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    // Request and scan payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        fstate_reg <= fstate_next;
        res_reg    <= res_next;
    end

endmodule

// ===== design/tuple_state_table_unit.sv =====
// ----------------------------------------------------------------------------
// tuple_state_table_unit: keyed table of tuple states
// Lookup, insert and state transitions of one key per request.
// ----------------------------------------------------------------------------
// Each request is looked up by a linear scan of the filled entries, one entry
// per cycle through a single key comparator reading the entry RAM; the input
// stalls from the accept until the result has been handed to the output
// register. Entries fill in order and are never removed, so a fill count
// marks the valid ones and no clearing pass is needed after reset. The result
// sits in an output register, so the next request is taken while a result
// waits to be drained.
module tuple_state_table_unit
    import tst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [63:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  found_state,
    output logic        key_found,
    output logic        changed,
    output logic        newly_added,
    output logic        table_full
);

    logic              res_valid;
    logic              res_ready;
    tst_result_t       res;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              out_valid_reg, out_valid_next;
    tst_result_t       out_reg;

    tst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key       (key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    tst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Take a new result when the output register is empty or draining
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found_state = out_reg.found_state;
    assign key_found   = out_reg.key_found;
    assign changed     = out_reg.changed;
    assign newly_added = out_reg.newly_added;
    assign table_full  = out_reg.table_full;

endmodule

// ===== tb/tuple_state_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tuple_state_table_unit_tb: self-checking bench of the tuple state table
// Drives a directed table of requests, then random requests over a key pool
// that fills the table and runs past it, with random idling, a long output
// hold-off and a drain pause. Results are held to typed rows or a shadow table.
// ----------------------------------------------------------------------------
module tuple_state_table_unit_tb;
    import tst_pkg::*;

    localparam int          CLK_HALF    = 5;
    localparam int          TOTAL_REQS  = 1050;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          POOL_SIZE   = 96;
    localparam logic [2:0]  REQ_SPARE_A = 3'd6;
    localparam logic [2:0]  REQ_SPARE_B = 3'd7;
    localparam logic [63:0] KEY_MASK    = (KEY_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : ((64'd1 << KEY_BITS) - 64'd1);

    typedef struct {
        logic [2:0]  req;
        logic [63:0] key;
        bit          typed;
        tst_result_t want;
    } stim_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type    = REQ_GET;
    logic [63:0] key         = 64'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  found_state;
    logic        key_found;
    logic        changed;
    logic        newly_added;
    logic        table_full;

    // Shadow copy of the table
    logic [63:0] shadow_key   [ENTRIES];
    logic [1:0]  shadow_state [ENTRIES];
    int          shadow_used  = 0;

    tst_result_t pending_results [$];
    stim_row_t   dir_rows [$];
    logic [63:0] key_pool [POOL_SIZE];

    int sent_count    = 0;
    int mismatches    = 0;
    int result_count  = 0;
    int full_count    = 0;
    int added_count   = 0;
    int changed_count = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    tst_result_t got;
    tst_result_t want;

    // Quiet window: neither side idles
    wire calm = (sent_count >= 450) && (sent_count < 650);

    tuple_state_table_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found_state(found_state),
        .key_found  (key_found),
        .changed    (changed),
        .newly_added(newly_added),
        .table_full (table_full)
    );

    always #CLK_HALF clk = ~clk;

    // Compute the result of one request and advance the shadow table
    function automatic tst_result_t predict_request(input logic [2:0] rq,
                                                    input logic [63:0] k_in);
        tst_result_t r;
        logic [63:0] k;
        int          slot;
        r    = '0;
        k    = k_in & KEY_MASK;
        slot = -1;
        for (int i = 0; i < shadow_used; i++)
            if (slot < 0 && shadow_key[i] == k)
                slot = i;
        if (slot >= 0)
        begin
            r.key_found   = 1'b1;
            r.found_state = shadow_state[slot];
        end
        case (rq)
            REQ_INS_ANY, REQ_INS_ABS:
            begin
                if (slot >= 0)
                begin
                    if (r.found_state == ST_ABSENT ||
                        (rq == REQ_INS_ANY && r.found_state == ST_UNKNOWN))
                    begin
                        shadow_state[slot] = ST_PRESENT;
                        r.changed = 1'b1;
                    end
                end
                else if (shadow_used < ENTRIES)
                begin
                    shadow_key[shadow_used]   = k;
                    shadow_state[shadow_used] = ST_PRESENT;
                    shadow_used++;
                    r.changed     = 1'b1;
                    r.newly_added = 1'b1;
                end
                else
                    r.table_full = 1'b1;
            end
            REQ_DEMOTE:
            begin
                if (slot >= 0 && r.found_state == ST_PRESENT)
                begin
                    shadow_state[slot] = ST_UNKNOWN;
                    r.changed = 1'b1;
                end
            end
            REQ_DROP:
            begin
                if (slot >= 0 && r.found_state == ST_UNKNOWN)
                begin
                    shadow_state[slot] = ST_ABSENT;
                    r.changed = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [2:0] rq, input logic [63:0] k, input int typed,
                           input logic [1:0] fs, input int kf, input int ch,
                           input int na, input int tf);
        stim_row_t row;
        row.req   = rq;
        row.key   = k;
        row.typed = (typed != 0);
        row.want  = {fs, 1'(kf), 1'(ch), 1'(na), 1'(tf)};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Offer one request, wait for it to be taken, and queue its expected result
    task automatic offer_request(input logic [2:0] rq, input logic [63:0] k,
                                 input int typed, input tst_result_t typed_want);
        tst_result_t predicted;
        int          gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 7)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_request(rq, k);
        pending_results.insert(pending_results.size(), (typed != 0) ? typed_want : predicted);
        sent_count++;
    endtask

    function automatic logic [2:0] pick_request(input bit inserts_ok);
        int roll;
        roll = $urandom_range(0, 99);
        if (!inserts_ok)
            roll = 30 + (roll % 70);
        if (roll < 18)      return REQ_INS_ANY;
        else if (roll < 30) return REQ_INS_ABS;
        else if (roll < 50) return REQ_DEMOTE;
        else if (roll < 68) return REQ_DROP;
        else if (roll < 80) return REQ_GET;
        else if (roll < 92) return REQ_EXISTS;
        else if (roll < 96) return REQ_SPARE_A;
        else                return REQ_SPARE_B;
    endfunction

    // Main stimulus
    initial
    begin
        logic [63:0] k;
        logic [2:0]  rq;
        int          pool_top;
        bit          drained;

        // Directed rows; typed rows carry the result read off the spec
        add_row(REQ_GET,     64'h0, 1, ST_ABSENT,  0, 0, 0, 0);
        add_row(REQ_EXISTS,  '1,    1, ST_ABSENT,  0, 0, 0, 0);
        add_row(REQ_SPARE_A, 64'h0, 1, ST_ABSENT,  0, 0, 0, 0);
        add_row(REQ_SPARE_B, '1,    1, ST_ABSENT,  0, 0, 0, 0);
        add_row(REQ_DEMOTE,  64'h0123_4567_89AB_CDEF, 1, ST_ABSENT, 0, 0, 0, 0);
        add_row(REQ_DROP,    64'h0123_4567_89AB_CDEF, 1, ST_ABSENT, 0, 0, 0, 0);
        add_row(REQ_INS_ANY, 64'h0, 1, ST_ABSENT,  0, 1, 1, 0);
        add_row(REQ_INS_ABS, 64'h0, 1, ST_PRESENT, 1, 0, 0, 0);
        add_row(REQ_INS_ANY, 64'h0, 1, ST_PRESENT, 1, 0, 0, 0);
        add_row(REQ_DROP,    64'h0, 1, ST_PRESENT, 1, 0, 0, 0);
        add_row(REQ_DEMOTE,  64'h0, 1, ST_PRESENT, 1, 1, 0, 0);
        add_row(REQ_INS_ABS, 64'h0, 1, ST_UNKNOWN, 1, 0, 0, 0);
        add_row(REQ_DEMOTE,  64'h0, 1, ST_UNKNOWN, 1, 0, 0, 0);
        add_row(REQ_DROP,    64'h0, 1, ST_UNKNOWN, 1, 1, 0, 0);
        add_row(REQ_GET,     64'h0, 1, ST_ABSENT,  1, 0, 0, 0);
        add_row(REQ_DROP,    64'h0, 1, ST_ABSENT,  1, 0, 0, 0);
        add_row(REQ_DEMOTE,  64'h0, 1, ST_ABSENT,  1, 0, 0, 0);
        add_row(REQ_INS_ABS, 64'h0, 1, ST_ABSENT,  1, 1, 0, 0);
        add_row(REQ_INS_ABS, '1,    1, ST_ABSENT,  0, 1, 1, 0);
        add_row(REQ_DEMOTE,  '1,    1, ST_PRESENT, 1, 1, 0, 0);
        add_row(REQ_INS_ANY, '1,    1, ST_UNKNOWN, 1, 1, 0, 0);
        add_row(REQ_EXISTS,  '1,    1, ST_PRESENT, 1, 0, 0, 0);
        add_row(REQ_SPARE_B, '1,    1, ST_PRESENT, 1, 0, 0, 0);
        add_row(REQ_GET,     64'h8000_0000_0000_0000, 1, ST_ABSENT, 0, 0, 0, 0);
        add_row(REQ_INS_ANY, 64'hAAAA_5555_AAAA_5555, 0, ST_ABSENT, 0, 0, 0, 0);

        // Key pool with single-bit neighbors to exercise the key compare
        key_pool[0] = 64'h0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
        begin
            if (i % 4 == 3)
                key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
            else
                key_pool[i] = {$urandom, $urandom};
        end

        // Hold reset low, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].req, dir_rows[i].key, int'(dir_rows[i].typed),
                          dir_rows[i].want);

        // Random part: a small pool first, then a wide one that fills the table
        drained = 1'b0;
        while (sent_count < TOTAL_REQS)
        begin
            pool_top = (sent_count < 400) ? 39 : POOL_SIZE - 1;
            if (!drained && sent_count >= 250)
            begin
                // Pause the sender until every result is back
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 20)
            begin
                // Lifecycle of one key: insert, demote, drop or re-insert, look up
                k = key_pool[$urandom_range(0, pool_top)];
                offer_request($urandom_range(0, 1) ? REQ_INS_ANY : REQ_INS_ABS, k, 0, '0);
                offer_request(REQ_DEMOTE, k, 0, '0);
                offer_request($urandom_range(0, 3) == 0 ? REQ_INS_ANY : REQ_DROP, k, 0, '0);
                offer_request($urandom_range(0, 1) ? REQ_GET : REQ_EXISTS, k, 0, '0);
            end
            else if ($urandom_range(0, 99) < 10)
            begin
                // Noise: random keys, inserts allowed only late in the run
                k  = {$urandom, $urandom};
                rq = pick_request(sent_count >= 400);
                offer_request(rq, k, 0, '0);
            end
            else
            begin
                k  = key_pool[$urandom_range(0, pool_top)];
                rq = pick_request(1'b1);
                offer_request(rq, k, 0, '0);
            end
        end
        in_valid <= 1'b0;

        // Drain and let the block settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
        mismatches += pending_results.size();

        $display("Checked %0d results of %0d requests over %0d table entries in use.",
                 result_count, sent_count, shadow_used);
        $display("Inserts added %0d keys, %0d state changes, %0d refused on a full table.",
                 added_count, changed_count, full_count);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, none in the quiet window
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= 700)
        begin
            out_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {found_state, key_found, changed, newly_added, table_full};
            result_count++;
            full_count    += got.table_full;
            added_count   += got.newly_added;
            changed_count += got.changed;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("ERROR: result with nothing expected: state=%0d found=%0b",
                             got.found_state, got.key_found);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display({"ERROR: result %0d: exp state=%0d found=%0b chg=%0b ",
                                  "add=%0b full=%0b, got state=%0d found=%0b chg=%0b ",
                                  "add=%0b full=%0b"}, result_count,
                                 want.found_state, want.key_found, want.changed,
                                 want.newly_added, want.table_full,
                                 got.found_state, got.key_found, got.changed,
                                 got.newly_added, got.table_full);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results outstanding", pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
